// ===== sv/pip_pkg.sv =====
// Shared constants, command codes and control/status types of the point-in-polygon unit.
`default_nettype none

package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_WIDTH  = 32;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_W       = COORD_WIDTH + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int VERT_W       = 2 * COORD_WIDTH;
    localparam int CMD_W        = 2;
    localparam int S_FIELDS_W   = CMD_W + 2 * COORD_WIDTH;
    localparam int S_TDATA_W    = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_TDATA_W    = 8;
    localparam int DRAIN_CYCLES = 2;

    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_QUERY  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic              clear;
        logic              append;
        logic              start;
        logic              rd_en;
        logic              rd_first;
        logic [VIDX_W-1:0] rd_addr;
        logic              close_edge;
        logic              out_load;
    } pip_ctl_t;

    typedef struct packed {
        logic              query_ok;
        logic [VCNT_W-1:0] vcount;
    } pip_sts_t;

endpackage

`default_nettype wire

// ===== sv/point_in_polygon_test_unit.sv =====
// Top level of the point-in-polygon unit: stream ports, controller and datapath.
//
// Holds one polygon of up to 64 vertices and answers point queries by crossing
// parity, with the closing edge included and an inclusive bounding-box check.
// Clear and append words return no result; appends past capacity are dropped
// and set the truncated flag. A query against N >= 2 vertices with the point
// inside the box walks the polygon edges: the vertex memory has one read port,
// so the edge walk reads one vertex per cycle and feeds a three-stage subtract,
// multiply and compare pipeline. Other queries go straight to the result. A
// result waits in an output register; a query holds in its last cycle until
// that register is free.
`default_nettype none

module point_in_polygon_test_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [pip_pkg::S_TDATA_W-1:0]  s_tdata,  // cmd, coord_x, coord_y, zero pad
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [pip_pkg::M_TDATA_W-1:0]  m_tdata   // inside_res, truncated, zero pad
);

    import pip_pkg::*;

    pip_ctl_t                      ctl;
    pip_sts_t                      sts;
    logic [CMD_W-1:0]              cmd;
    logic signed [COORD_WIDTH-1:0] coord_x, coord_y;
    logic                          inside_res, truncated;

    assign cmd     = s_tdata[CMD_W-1:0];
    assign coord_x = signed'(s_tdata[CMD_W +: COORD_WIDTH]);
    assign coord_y = signed'(s_tdata[CMD_W + COORD_WIDTH +: COORD_WIDTH]);

    pip_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    pip_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .ctl        (ctl),
        .sts        (sts),
        .inside_res (inside_res),
        .truncated  (truncated)
    );

    assign m_tdata = {{(M_TDATA_W-2){1'b0}}, truncated, inside_res};

endmodule

`default_nettype wire

// ===== sv/pip_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pip_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/pip_ctrl.sv =====
// Controller state machine: command decode, vertex walk sequencing and result handoff.
`default_nettype none

module pip_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [pip_pkg::CMD_W-1:0] cmd,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    input  wire pip_pkg::pip_sts_t         sts,
    output pip_pkg::pip_ctl_t              ctl
);

    import pip_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_LAST,
        S_CLOSE,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [VCNT_W-1:0] idx_reg, idx_next;
    logic [VCNT_W-1:0] idx_inc;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              accept;
    logic              out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign idx_inc  = idx_reg + VCNT_W'(1);

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ctl           = '0;
        ctl.rd_addr   = idx_reg[VIDX_W-1:0];
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (cmd_t'(cmd))
                        CMD_CLEAR:  ctl.clear  = 1'b1;
                        CMD_APPEND: ctl.append = 1'b1;
                        CMD_QUERY: begin
                            ctl.start  = 1'b1;
                            idx_next   = '0;
                            state_next = sts.query_ok ? S_WALK : S_DONE;
                        end
                        default: ;
                    endcase
                end
            end
            S_WALK: begin
                ctl.rd_en    = 1'b1;
                ctl.rd_first = (idx_reg == '0);
                idx_next     = idx_inc;
                if (idx_inc == sts.vcount) begin
                    state_next = S_LAST;
                end
            end
            S_LAST: begin
                state_next = S_CLOSE;
            end
            S_CLOSE: begin
                ctl.close_edge = 1'b1;
                idx_next       = '0;
                state_next     = S_DRAIN;
            end
            S_DRAIN: begin
                idx_next = idx_inc;
                if (idx_reg == VCNT_W'(DRAIN_CYCLES - 1)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    ctl.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    a_walk_needs_two: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (sts.vcount >= VCNT_W'(2)))
        else $error("walk with fewer than two vertices");

    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside done state");

endmodule

`default_nettype wire

// ===== sv/pip_dpath.sv =====
// Datapath: vertex memory, bounding box, edge crossing pipeline and result register.
`default_nettype none

module pip_dpath (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic signed [pip_pkg::COORD_WIDTH-1:0] coord_x,
    input  wire logic signed [pip_pkg::COORD_WIDTH-1:0] coord_y,
    input  wire pip_pkg::pip_ctl_t                      ctl,
    output pip_pkg::pip_sts_t                           sts,
    output logic                                        inside_res,
    output logic                                        truncated
);

    import pip_pkg::*;

    logic [VCNT_W-1:0]             count_reg;
    logic                          overflow_reg;
    logic signed [COORD_WIDTH-1:0] min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    logic signed [COORD_WIDTH-1:0] qx_reg, qy_reg;
    logic                          room;
    logic                          in_box;

    logic [VERT_W-1:0]             rdata;
    logic                          rv_reg, rfirst_reg;
    logic [VERT_W-1:0]             first_reg, prev_reg;
    logic [VERT_W-1:0]             cur;
    logic signed [COORD_WIDTH-1:0] x0, y0, x1, y1;
    logic                          edge_go, straddle;
    logic signed [DIFF_W-1:0]      d_a, d_dy, d_b, d_dx;

    logic                          s1_valid_reg, s1_pos_reg;
    logic signed [DIFF_W-1:0]      s1_a_reg, s1_dy_reg, s1_b_reg, s1_dx_reg;
    logic                          s2_valid_reg, s2_pos_reg;
    logic signed [PROD_W-1:0]      s2_p_reg, s2_q_reg;
    logic                          hit;
    logic                          parity_reg, parity_next;
    logic                          inside_reg, trunc_reg;

    assign room   = (count_reg < VCNT_W'(MAX_VERTICES));
    assign in_box = (coord_x >= min_x_reg) && (coord_x <= max_x_reg) &&
                    (coord_y >= min_y_reg) && (coord_y <= max_y_reg);

    assign sts.query_ok = (count_reg >= VCNT_W'(2)) && in_box;
    assign sts.vcount   = count_reg;

    pip_ram #(
        .WIDTH (VERT_W),
        .DEPTH (MAX_VERTICES)
    ) u_vert_ram (
        .aclk  (aclk),
        .we    (ctl.append && room),
        .waddr (count_reg[VIDX_W-1:0]),
        .wdata ({coord_y, coord_x}),
        .re    (ctl.rd_en),
        .raddr (ctl.rd_addr),
        .rdata (rdata)
    );

    // Polygon state: count, box, overflow
    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            min_x_reg    <= COORD_MAX;
            min_y_reg    <= COORD_MAX;
            max_x_reg    <= COORD_MIN;
            max_y_reg    <= COORD_MIN;
        end else if (ctl.append) begin
            if (room) begin
                count_reg <= count_reg + VCNT_W'(1);
                if (coord_x < min_x_reg) min_x_reg <= coord_x;
                if (coord_x > max_x_reg) max_x_reg <= coord_x;
                if (coord_y < min_y_reg) min_y_reg <= coord_y;
                if (coord_y > max_y_reg) max_y_reg <= coord_y;
            end else begin
                overflow_reg <= 1'b1;
            end
        end
    end

    // Edge source: previous vertex to current read or back to the first vertex
    assign edge_go = (rv_reg && !rfirst_reg) || ctl.close_edge;
    assign cur     = ctl.close_edge ? first_reg : rdata;
    assign x0      = signed'(prev_reg[COORD_WIDTH-1:0]);
    assign y0      = signed'(prev_reg[VERT_W-1:COORD_WIDTH]);
    assign x1      = signed'(cur[COORD_WIDTH-1:0]);
    assign y1      = signed'(cur[VERT_W-1:COORD_WIDTH]);

    assign straddle = ((y0 <= qy_reg) && (y1 > qy_reg)) || ((y0 > qy_reg) && (y1 <= qy_reg));
    assign d_a  = signed'({qx_reg[COORD_WIDTH-1], qx_reg}) - signed'({x0[COORD_WIDTH-1], x0});
    assign d_b  = signed'({qy_reg[COORD_WIDTH-1], qy_reg}) - signed'({y0[COORD_WIDTH-1], y0});
    assign d_dy = signed'({y1[COORD_WIDTH-1], y1}) - signed'({y0[COORD_WIDTH-1], y0});
    assign d_dx = signed'({x1[COORD_WIDTH-1], x1}) - signed'({x0[COORD_WIDTH-1], x0});

    assign hit         = s2_pos_reg ? (s2_p_reg < s2_q_reg) : (s2_q_reg < s2_p_reg);
    assign parity_next = parity_reg ^ (s2_valid_reg && hit);

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            qx_reg <= coord_x;
            qy_reg <= coord_y;
        end
        if (rv_reg) begin
            prev_reg <= rdata;
            if (rfirst_reg) begin
                first_reg <= rdata;
            end
        end
        s1_pos_reg <= (y1 > y0);
        s1_a_reg   <= d_a;
        s1_dy_reg  <= d_dy;
        s1_b_reg   <= d_b;
        s1_dx_reg  <= d_dx;
        s2_pos_reg <= s1_pos_reg;
        s2_p_reg   <= PROD_W'(s1_a_reg) * PROD_W'(s1_dy_reg);
        s2_q_reg   <= PROD_W'(s1_b_reg) * PROD_W'(s1_dx_reg);
        if (ctl.out_load) begin
            inside_reg <= parity_reg;
            trunc_reg  <= overflow_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg       <= 1'b0;
            rfirst_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            parity_reg   <= 1'b0;
        end else begin
            rv_reg       <= ctl.rd_en;
            rfirst_reg   <= ctl.rd_first;
            s1_valid_reg <= edge_go && straddle;
            s2_valid_reg <= s1_valid_reg;
            parity_reg   <= ctl.start ? 1'b0 : parity_next;
        end
    end

    assign inside_res = inside_reg;
    assign truncated  = trunc_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= VCNT_W'(MAX_VERTICES))
        else $error("vertex count beyond capacity");

    a_close_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.close_edge && rv_reg))
        else $error("closing edge collides with read data");

    a_box_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != '0) |-> ((min_x_reg <= max_x_reg) && (min_y_reg <= max_y_reg)))
        else $error("bounding box inverted");

endmodule

`default_nettype wire
